// ===== hw/rtl/slr_pkg.sv =====
// slr_pkg: shared types and constants for the stereo linear resampler
// payload structs, register indexes, sequencer states and block limits
// no dependencies
package slr_pkg;

  localparam int unsigned MAX_BLOCK_PAIRS = 16384;
  localparam int unsigned MAX_RUN         = 16;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned OLD_W       = 15;
  localparam int unsigned NEW_W       = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned DONE_W      = 17;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned RUN_W       = $clog2(MAX_RUN + 1);
  localparam int unsigned CAP_W       = $clog2(MAX_BLOCK_PAIRS * MAX_RUN + 1);
  localparam int unsigned PROD_W      = 33;
  localparam int unsigned DIV_STEPS   = 16;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CFG_INDEX_W-1:0] REG_OLD_COUNT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_NEW_COUNT = CFG_INDEX_W'(1);

  localparam logic [OLD_W-1:0] OLD_COUNT_RESET = OLD_W'(1024);
  localparam logic [NEW_W-1:0] NEW_COUNT_RESET = NEW_W'(1024);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       run_last;
    logic                       block_last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_DIV_INIT,
    ST_DIV,
    ST_STORE,
    ST_PUSH,
    ST_FINISH
  } seq_state_t;

endpackage

// ===== hw/rtl/stereo_linear_resampler.sv =====
// stereo_linear_resampler: top level, sequencer around one multiplier and one divider
// depends on slr_pkg
//
// Each accepted stereo pair yields from zero to sixteen interpolated output pairs, one
// result request each. All outputs run through one 16 by 17 bit multiplier and one
// restoring divider that retires one quotient bit a cycle, left channel then right.
// Per output pair there is a check, then per channel two multiplies, a sum, a divider
// set-up, sixteen divider steps and a store, then a push, which waits while the result
// register holds a result that result_ready has not yet taken. The block takes no sample
// while one is being worked on. A write to either count register restarts the block,
// but keeps the last pair held for interpolation.
module stereo_linear_resampler (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [slr_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [slr_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  slr_pkg::sample_t                      sample,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output slr_pkg::result_t                      result
);

  slr_pkg::seq_state_t state, state_next;

  logic [slr_pkg::OLD_W-1:0]          old_count;
  logic [slr_pkg::NEW_W-1:0]          new_count;
  logic signed [slr_pkg::SAMPLE_W-1:0] prev_left, prev_right;
  logic signed [slr_pkg::SAMPLE_W-1:0] cur_left, cur_right;
  logic [slr_pkg::OLD_W-1:0]          pairs_seen;
  logic [slr_pkg::DONE_W-1:0]         outputs_done;
  logic [slr_pkg::POS_W-1:0]          position_numerator;
  logic [slr_pkg::POS_W-1:0]          base;
  logic [slr_pkg::POS_W-1:0]          limit;
  logic [slr_pkg::RUN_W-1:0]          run_count;
  logic [slr_pkg::NEW_W-1:0]          weight;
  logic                               chan;
  logic signed [slr_pkg::PROD_W-1:0]  prod;
  logic signed [slr_pkg::PROD_W-1:0]  acc;
  logic [slr_pkg::NEW_W-1:0]          rem;
  logic [slr_pkg::SAMPLE_W-1:0]       quo;
  logic                               neg;
  logic [slr_pkg::DIV_CNT_W-1:0]      div_cnt;
  logic signed [slr_pkg::SAMPLE_W-1:0] res_left, res_right;

  logic [slr_pkg::OLD_W-1:0]          o_eff;
  logic [slr_pkg::CAP_W-1:0]          cap;
  logic [slr_pkg::NEW_W-1:0]          n_eff;
  logic                               sample_acc;
  logic                               push_ok;
  logic                               more;
  logic                               has_next;
  logic [slr_pkg::POS_W-1:0]          r_full;
  logic [slr_pkg::NEW_W-1:0]          r_val;
  logic signed [slr_pkg::SAMPLE_W-1:0] mul_x;
  logic [slr_pkg::NEW_W-1:0]          mul_y;
  logic signed [slr_pkg::PROD_W-1:0]  mul_p;
  logic signed [slr_pkg::PROD_W-1:0]  mag;
  logic [slr_pkg::NEW_W:0]            trial;
  logic                               trial_ge;
  logic [slr_pkg::SAMPLE_W-1:0]       quo_signed;
  logic [slr_pkg::OLD_W:0]            pairs_inc;

  // effective block sizes
  always_comb begin
    if (old_count == '0) begin
      o_eff = slr_pkg::OLD_W'(1);
    end else if (32'(old_count) > slr_pkg::MAX_BLOCK_PAIRS) begin
      o_eff = slr_pkg::OLD_W'(slr_pkg::MAX_BLOCK_PAIRS);
    end else begin
      o_eff = old_count;
    end
    cap = slr_pkg::CAP_W'(o_eff) * slr_pkg::CAP_W'(slr_pkg::MAX_RUN);
    if (new_count == '0) begin
      n_eff = slr_pkg::NEW_W'(1);
    end else if (slr_pkg::CAP_W'(new_count) > cap) begin
      n_eff = cap[slr_pkg::NEW_W-1:0];
    end else begin
      n_eff = new_count;
    end
  end

  // remainder of the output position within the current pair
  always_comb begin
    r_full = (position_numerator >= base) ? position_numerator - base : '0;
    if (r_full > slr_pkg::POS_W'(n_eff)) begin
      r_val = n_eff;
    end else begin
      r_val = r_full[slr_pkg::NEW_W-1:0];
    end
  end

  assign more = (run_count < slr_pkg::RUN_W'(slr_pkg::MAX_RUN))
             && (outputs_done < slr_pkg::DONE_W'(n_eff))
             && (position_numerator < limit);

  assign has_next = (run_count + slr_pkg::RUN_W'(1) < slr_pkg::RUN_W'(slr_pkg::MAX_RUN))
                 && (outputs_done + slr_pkg::DONE_W'(1) < slr_pkg::DONE_W'(n_eff))
                 && (position_numerator + slr_pkg::POS_W'(o_eff) < limit);

  // shared multiplier
  always_comb begin
    if (state == slr_pkg::ST_MUL_A) begin
      mul_x = chan ? prev_right : prev_left;
      mul_y = n_eff - weight;
    end else begin
      mul_x = chan ? cur_right : cur_left;
      mul_y = weight;
    end
    mul_p = slr_pkg::PROD_W'(mul_x) * $signed({1'b0, mul_y});
  end

  // divider step
  assign mag        = acc[slr_pkg::PROD_W-1] ? -acc : acc;
  assign trial      = {rem, quo[slr_pkg::SAMPLE_W-1]};
  assign trial_ge   = trial >= {1'b0, n_eff};
  assign quo_signed = neg ? -quo : quo;
  assign pairs_inc  = {1'b0, pairs_seen} + (slr_pkg::OLD_W+1)'(1);

  assign sample_acc = sample_valid && sample_ready;
  assign push_ok    = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    case (state)
      slr_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          state_next = slr_pkg::ST_CHECK;
        end
      end
      slr_pkg::ST_CHECK:    state_next = more ? slr_pkg::ST_MUL_A : slr_pkg::ST_FINISH;
      slr_pkg::ST_MUL_A:    state_next = slr_pkg::ST_MUL_B;
      slr_pkg::ST_MUL_B:    state_next = slr_pkg::ST_SUM;
      slr_pkg::ST_SUM:      state_next = slr_pkg::ST_DIV_INIT;
      slr_pkg::ST_DIV_INIT: state_next = slr_pkg::ST_DIV;
      slr_pkg::ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = slr_pkg::ST_STORE;
        end
      end
      slr_pkg::ST_STORE:    state_next = chan ? slr_pkg::ST_PUSH : slr_pkg::ST_MUL_A;
      slr_pkg::ST_PUSH: begin
        if (push_ok) begin
          state_next = slr_pkg::ST_CHECK;
        end
      end
      slr_pkg::ST_FINISH:   state_next = slr_pkg::ST_IDLE;
      default:              state_next = slr_pkg::ST_IDLE;
    endcase
  end

  // control and held state
  always_ff @(posedge clk) begin
    if (rst) begin
      old_count          <= slr_pkg::OLD_COUNT_RESET;
      new_count          <= slr_pkg::NEW_COUNT_RESET;
      prev_left          <= '0;
      prev_right         <= '0;
      pairs_seen         <= '0;
      outputs_done       <= '0;
      position_numerator <= '0;
      base               <= '0;
      result_valid       <= 1'b0;
    end else begin
      if (cfg_write && (cfg_index == slr_pkg::REG_OLD_COUNT
                        || cfg_index == slr_pkg::REG_NEW_COUNT)) begin
        if (cfg_index == slr_pkg::REG_OLD_COUNT) begin
          old_count <= cfg_data[slr_pkg::OLD_W-1:0];
        end else begin
          new_count <= cfg_data[slr_pkg::NEW_W-1:0];
        end
        pairs_seen         <= '0;
        outputs_done       <= '0;
        position_numerator <= '0;
        base               <= '0;
      end
      if (state == slr_pkg::ST_PUSH && push_ok) begin
        result_valid       <= 1'b1;
        outputs_done       <= outputs_done + slr_pkg::DONE_W'(1);
        position_numerator <= position_numerator + slr_pkg::POS_W'(o_eff);
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (state == slr_pkg::ST_FINISH) begin
        prev_left  <= cur_left;
        prev_right <= cur_right;
        if (pairs_inc >= (slr_pkg::OLD_W+1)'(o_eff)) begin
          pairs_seen         <= '0;
          outputs_done       <= '0;
          position_numerator <= '0;
          base               <= '0;
        end else begin
          pairs_seen <= pairs_inc[slr_pkg::OLD_W-1:0];
          base       <= base + slr_pkg::POS_W'(n_eff);
        end
      end
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk) begin
    case (state)
      slr_pkg::ST_IDLE: begin
        if (sample_acc) begin
          cur_left  <= sample.in_left;
          cur_right <= sample.in_right;
          limit     <= base + slr_pkg::POS_W'(n_eff);
          run_count <= '0;
        end
      end
      slr_pkg::ST_CHECK: begin
        weight <= r_val;
        chan   <= 1'b0;
      end
      slr_pkg::ST_MUL_A: begin
        prod <= mul_p;
      end
      slr_pkg::ST_MUL_B: begin
        acc  <= prod;
        prod <= mul_p;
      end
      slr_pkg::ST_SUM: begin
        acc <= acc + prod;
      end
      slr_pkg::ST_DIV_INIT: begin
        neg     <= acc[slr_pkg::PROD_W-1];
        rem     <= {1'b0, mag[30:slr_pkg::SAMPLE_W]};
        quo     <= mag[slr_pkg::SAMPLE_W-1:0];
        div_cnt <= slr_pkg::DIV_CNT_W'(slr_pkg::DIV_STEPS - 1);
      end
      slr_pkg::ST_DIV: begin
        if (trial_ge) begin
          rem <= slr_pkg::NEW_W'(trial - {1'b0, n_eff});
        end else begin
          rem <= trial[slr_pkg::NEW_W-1:0];
        end
        quo     <= {quo[slr_pkg::SAMPLE_W-2:0], trial_ge};
        div_cnt <= div_cnt - slr_pkg::DIV_CNT_W'(1);
      end
      slr_pkg::ST_STORE: begin
        if (chan) begin
          res_right <= quo_signed;
        end else begin
          res_left <= quo_signed;
          chan     <= 1'b1;
        end
      end
      slr_pkg::ST_PUSH: begin
        if (push_ok) begin
          result.out_left   <= res_left;
          result.out_right  <= res_right;
          result.run_last   <= !has_next;
          result.block_last <= (outputs_done + slr_pkg::DONE_W'(1)) == slr_pkg::DONE_W'(n_eff);
          run_count         <= run_count + slr_pkg::RUN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/slr_checker.sv =====
`timescale 1ns / 1ps
// slr_checker: watches the register port and the sample and result requests of the resampler
// keeps its own copy of the block state, predicts every output pair and compares in order
// depends on slr_pkg
module slr_checker
  import slr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   sample_valid,
  input  logic                   sample_ready,
  input  sample_t                sample,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  result_t                result,
  output int                     failures,
  output int                     pending
);

  logic [OLD_W-1:0]           old_reg;
  logic [NEW_W-1:0]           new_reg;
  logic signed [SAMPLE_W-1:0] hold_left;
  logic signed [SAMPLE_W-1:0] hold_right;
  logic [OLD_W-1:0]           pairs_in;
  logic [DONE_W-1:0]          outs_done;
  logic [POS_W-1:0]           pos_num;
  result_t                    expected_outputs[$];

  function automatic logic signed [SAMPLE_W-1:0] blend(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [31:0]                n,
    input logic [31:0]                r
  );
    longint s;
    longint q;
    s = longint'(a) * longint'(n - r) + longint'(b) * longint'(r);
    q = s / longint'(n);
    return q[SAMPLE_W-1:0];
  endfunction

  task automatic restart_block();
    pairs_in  = '0;
    outs_done = '0;
    pos_num   = '0;
  endtask

  task automatic apply_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_OLD_COUNT) begin
      old_reg = val[OLD_W-1:0];
      restart_block();
    end else if (idx == REG_NEW_COUNT) begin
      new_reg = val[NEW_W-1:0];
      restart_block();
    end
  endtask

  task automatic resample_pair(input sample_t p);
    logic [31:0] o;
    logic [31:0] n;
    logic [31:0] cap;
    logic [31:0] base;
    logic [31:0] lim;
    logic [31:0] r;
    result_t     res;
    int          count;
    o = (old_reg == '0) ? 32'd1 : 32'(old_reg);
    if (o > MAX_BLOCK_PAIRS) o = MAX_BLOCK_PAIRS;
    n = (new_reg == '0) ? 32'd1 : 32'(new_reg);
    cap = MAX_RUN * o;
    if (n > cap) n = cap;
    base  = pairs_in * n;
    lim   = base + n;
    count = 0;
    while (count < MAX_RUN && outs_done < n && pos_num < lim) begin
      r = (pos_num >= base) ? pos_num - base : 32'd0;
      if (r > n) r = n;
      res.out_left   = blend(hold_left, p.in_left, n, r);
      res.out_right  = blend(hold_right, p.in_right, n, r);
      res.block_last = (outs_done + 1 == n);
      outs_done++;
      pos_num += o;
      count++;
      res.run_last = !(count < MAX_RUN && outs_done < n && pos_num < lim);
      expected_outputs.push_back(res);
    end
    hold_left  = p.in_left;
    hold_right = p.in_right;
    pairs_in++;
    if (pairs_in >= o) restart_block();
  endtask

  task automatic check_output(input result_t got);
    result_t want;
    if (expected_outputs.size() == 0) begin
      $display("%0t: expected no result, got left %0d right %0d run_last %0b block_last %0b",
               $time, got.out_left, got.out_right, got.run_last, got.block_last);
      failures++;
    end else begin
      want = expected_outputs.pop_front();
      if (got !== want) begin
        failures++;
        if (got.out_left !== want.out_left)
          $display("%0t: out_left expected %0d got %0d", $time, want.out_left, got.out_left);
        if (got.out_right !== want.out_right)
          $display("%0t: out_right expected %0d got %0d", $time, want.out_right, got.out_right);
        if (got.run_last !== want.run_last)
          $display("%0t: run_last expected %0b got %0b", $time, want.run_last, got.run_last);
        if (got.block_last !== want.block_last)
          $display("%0t: block_last expected %0b got %0b", $time, want.block_last,
                   got.block_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      old_reg    = OLD_COUNT_RESET;
      new_reg    = NEW_COUNT_RESET;
      hold_left  = '0;
      hold_right = '0;
      restart_block();
      expected_outputs.delete();
      failures   = 0;
    end else begin
      if (result_valid && result_ready) check_output(result);
      if (cfg_write) apply_write(cfg_index, cfg_data);
      if (sample_valid && sample_ready) resample_pair(sample);
    end
    pending = expected_outputs.size();
  end

endmodule

// ===== tb/stereo_linear_resampler_tb.sv =====
`timescale 1ns / 1ps
// stereo_linear_resampler_tb: drives stereo pairs and register writes into the resampler
// with random gaps on both requests, and gives the verdict from the checker's failure and pending counts
// depends on slr_pkg, slr_checker and stereo_linear_resampler
module stereo_linear_resampler_tb;
  import slr_pkg::*;

  localparam int QUIET_CYCLES = 64;
  localparam int RANDOM_PAIRS = 360;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_2 = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_3 = CFG_INDEX_W'(3);

  localparam logic [SAMPLE_W-1:0] CORNERS [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   sample_valid = 1'b0;
  logic                   sample_ready;
  sample_t                sample_in    = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result_out;
  int                     failure_count;
  int                     pending_count;
  bit                     steady       = 1'b0;

  always #4 clk = ~clk;

  stereo_linear_resampler dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_out)
  );

  slr_checker resampler_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_out),
    .failures     (failure_count),
    .pending      (pending_count)
  );

  function automatic sample_t pick_pair();
    sample_t p;
    p = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      p.in_left  = CORNERS[$urandom_range(0, 3)];
      p.in_right = CORNERS[$urandom_range(0, 3)];
    end
    return p;
  endfunction

  task automatic send_pair(input sample_t p);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_in    <= p;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // result side: fresh random stall, possibly none, before every result request
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int                    sent;
    int                    phase_len;
    bit                    spare_mid;
    logic [CFG_DATA_W-1:0] old_val;
    logic [CFG_DATA_W-1:0] new_val;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, one output per pair
    send_pair(sample_t'{16'h8000, 16'h7fff});
    send_pair(sample_t'{16'h7fff, 16'h8000});
    send_pair(sample_t'{16'hffff, 16'h0000});
    send_pair(sample_t'{16'h0000, 16'hffff});

    // zero counts fall back to one
    settle();
    write_register(REG_OLD_COUNT, 16'h0000);
    write_register(REG_NEW_COUNT, 16'h0000);
    repeat (3) send_pair(pick_pair());

    // new count saturated to sixteen outputs per pair
    settle();
    write_register(REG_OLD_COUNT, 16'h0001);
    write_register(REG_NEW_COUNT, 16'hffff);
    send_pair(sample_t'{16'h8000, 16'h7fff});
    send_pair(sample_t'{16'h7fff, 16'h8000});

    // downsampling, some pairs give no output
    settle();
    write_register(REG_OLD_COUNT, 16'h0003);
    write_register(REG_NEW_COUNT, 16'h0002);
    repeat (6) send_pair(pick_pair());

    // write to an unused index leaves the block running
    settle();
    write_register(REG_NEW_COUNT, 16'h0005);
    repeat (2) send_pair(pick_pair());
    settle();
    write_register(REG_UNUSED_2, 16'hffff);
    write_register(REG_UNUSED_3, 16'h5a5a);
    repeat (3) send_pair(pick_pair());

    // old count beyond the block limit
    settle();
    write_register(REG_OLD_COUNT, 16'hffff);
    write_register(REG_NEW_COUNT, 16'hffff);
    repeat (3) send_pair(pick_pair());

    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      settle();
      case ($urandom_range(0, 7))
        0: begin
          old_val = CFG_DATA_W'($urandom);
          new_val = CFG_DATA_W'($urandom);
        end
        1: begin
          case ($urandom_range(0, 5))
            0: old_val = 16'd0;
            1: old_val = 16'd1;
            2: old_val = 16'd16384;
            3: old_val = 16'd16385;
            4: old_val = 16'h7fff;
            default: old_val = 16'hffff;
          endcase
          case ($urandom_range(0, 3))
            0: new_val = 16'd0;
            1: new_val = 16'd1;
            2: new_val = 16'hffff;
            default: new_val = CFG_DATA_W'($urandom_range(1, 16));
          endcase
        end
        default: begin
          old_val = CFG_DATA_W'($urandom_range(1, 8));
          new_val = CFG_DATA_W'($urandom_range(1, 16 * old_val + 4));
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_register(REG_OLD_COUNT, old_val);
        write_register(REG_NEW_COUNT, new_val);
      end else begin
        write_register(REG_NEW_COUNT, new_val);
        write_register(REG_OLD_COUNT, old_val);
      end
      if ($urandom_range(0, 3) == 0)
        write_register($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                       CFG_DATA_W'($urandom));
      steady    = ($urandom_range(0, 3) == 0);
      spare_mid = ($urandom_range(0, 5) == 0);
      phase_len = $urandom_range(6, 40);
      for (int i = 0; i < phase_len; i++) begin
        if (spare_mid && i == phase_len / 2) begin
          settle();
          write_register($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                         CFG_DATA_W'($urandom));
        end
        send_pair(pick_pair());
        sent++;
      end
    end

    settle();
    if (failure_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #12ms;
    $display("Verification failed");
    $finish;
  end

endmodule
